// File: hw/rtl/aars_pkg.sv
// ----------------------------------------------------------------------------
// Autorange scaler package
// Shared constants, sequencer states and the divider request and response
// types of the analog axis autorange scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package aars_pkg;

	// Number of analog channels that are served.
	localparam int NUM_CHANNELS = 8;
	// Bits of a store index.
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Field widths.
	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 12;
	localparam int VAL_W    = 17;
	localparam int AXIS_W   = 16;
	localparam int SPAN_W   = 16;

	// Channel count as a value that compares against a channel field.
	localparam logic [CH_W:0] NUM_CH_LIMIT = (CH_W + 1)'(NUM_CHANNELS);

	// Centering offset and clip limit of the axis value.
	localparam logic signed [VAL_W-1:0] AXIS_LIMIT = 17'sd32767;
	localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;
	localparam logic signed [AXIS_W-1:0] AXIS_MIN = -16'sh7FFF;

	// Reset values of the tracked extremes.
	localparam logic signed [VAL_W-1:0] TRACK_MIN_RESET = 17'sh0FFFF;
	localparam logic signed [VAL_W-1:0] TRACK_MAX_RESET = 17'sh10000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTORANGE    = 4'd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRACK,
		ST_CHECK,
		ST_DIV,
		ST_SCALE,
		ST_DONE
	} state_t;

	// Divider request: quotient of offset * 65535 / span.
	typedef struct packed {
		logic              start;
		logic [SPAN_W-1:0] offset;
		logic [SPAN_W-1:0] span;
	} div_req_t;

	// Divider response.
	typedef struct packed {
		logic              done;
		logic [SPAN_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/aars_div.sv
// ----------------------------------------------------------------------------
// Autorange serial divider
// Restoring divider that forms offset * 65535 / span, one quotient bit per
// cycle. The offset never exceeds the span, so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aars_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire aars_pkg::div_req_t req,
	output aars_pkg::div_rsp_t     rsp
);

	localparam int W = aars_pkg::SPAN_W;

	logic [W-1:0]         rem_q;
	logic [W-1:0]         quo_q;
	logic [W-1:0]         dvs_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [2*W-1:0] dividend;
	logic [W:0]     trial;
	logic           fits;
	logic [W:0]     trial_sub;

	// Scaling by 65535 is a shift and a subtract.
	assign dividend = {req.offset, {W{1'b0}}} - {{W{1'b0}}, req.offset};

	// One restoring step: bring down the next dividend bit and try the span.
	assign trial     = {rem_q, quo_q[W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ($clog2(W))'(W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient; the low dividend half shifts out as
	// quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dividend[2*W-1:W];
			quo_q <= dividend[W-1:0];
			dvs_q <= req.span;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/aars_track.sv
// ----------------------------------------------------------------------------
// Autorange extreme store
// Per-channel running minimum and maximum of the axis value, with the
// updated pair for the addressed channel and a clear of all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module aars_track (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   clear,
	input  wire logic                                   update,
	input  wire logic [aars_pkg::CH_IDX_W-1:0]          idx,
	input  wire logic signed [aars_pkg::VAL_W-1:0]      value,
	output logic signed [aars_pkg::VAL_W-1:0]           new_min,
	output logic signed [aars_pkg::VAL_W-1:0]           new_max
);

	logic signed [aars_pkg::VAL_W-1:0] min_q [aars_pkg::NUM_CHANNELS];
	logic signed [aars_pkg::VAL_W-1:0] max_q [aars_pkg::NUM_CHANNELS];

	// Extremes after taking the current value into account.
	always_comb begin
		new_min = (value < min_q[idx]) ? value : min_q[idx];
		new_max = (value > max_q[idx]) ? value : max_q[idx];
	end

	// Store, cleared by reset and by an autorange register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aars_pkg::NUM_CHANNELS; i++) begin
				min_q[i] <= aars_pkg::TRACK_MIN_RESET;
				max_q[i] <= aars_pkg::TRACK_MAX_RESET;
			end
		end else if (clear) begin
			for (int i = 0; i < aars_pkg::NUM_CHANNELS; i++) begin
				min_q[i] <= aars_pkg::TRACK_MIN_RESET;
				max_q[i] <= aars_pkg::TRACK_MAX_RESET;
			end
		end else if (update) begin
			min_q[idx] <= new_min;
			max_q[idx] <= new_max;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/analog_axis_autorange_scaler_unit.sv
// ----------------------------------------------------------------------------
// Analog axis autorange scaler
// Turns 12-bit ADC samples into centered signed axis values, with optional
// per-channel min/max tracking and rescaling to the full axis span.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata raw_sample, tuser channel
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata axis_value, tuser out_channel
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A masked sample gives no request on m_axis. Without autoranging an item goes
// from idle straight to completion. With autoranging the rescaled value is
// formed by the 16-step serial divider, which is skipped when the spread is 0
// or 1 and no division is needed.
// The input is ready only in idle; a finished result waits in the output
// register, so the next sample is taken while m_axis stalls.
// Reset sets the control registers and the tracked extremes at once; the datapath registers are not reset.
//
`default_nettype none

module analog_axis_autorange_scaler_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Sample input.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [11:0] raw_sample, [15:12] zero
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] channel
	// Axis value output.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [15:0] axis_value
	output logic [2:0]       m_axis_tuser,  // [2:0] out_channel
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [aars_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aars_pkg::CFG_DATA_W-1:0] cfg_data
);

	aars_pkg::state_t state_q;
	aars_pkg::state_t state_d;

	logic [aars_pkg::NUM_CHANNELS-1:0]  mask_q;
	logic                               auto_q;
	logic [aars_pkg::CH_W-1:0]          ch_q;
	logic signed [aars_pkg::VAL_W-1:0]  val_q;
	logic [aars_pkg::SPAN_W-1:0]        range_q;
	logic [aars_pkg::SPAN_W-1:0]        offset_q;
	logic signed [aars_pkg::AXIS_W-1:0] res_q;

	logic                               out_valid_q;
	logic [aars_pkg::AXIS_W-1:0]        out_data_q;
	logic [aars_pkg::CH_W-1:0]          out_ch_q;

	logic                               in_accept;
	logic                               ch_enabled;
	logic signed [aars_pkg::VAL_W-1:0]  in_val;
	logic                               cfg_write;
	logic                               trk_clear;
	logic                               trk_update;
	logic signed [aars_pkg::VAL_W-1:0]  new_min;
	logic signed [aars_pkg::VAL_W-1:0]  new_max;
	logic signed [aars_pkg::VAL_W-1:0]  span_full;
	logic signed [aars_pkg::VAL_W-1:0]  offset_full;
	logic signed [aars_pkg::VAL_W-1:0]  scaled;
	logic                               out_free;
	logic                               in_ready;
	logic                               div_start;
	aars_pkg::div_req_t                 div_req;
	aars_pkg::div_rsp_t                 div_rsp;

	// Input decode: channel enable and the centered value.
	assign in_accept  = s_axis_tvalid && s_axis_tready;
	assign ch_enabled = ({1'b0, s_axis_tuser} < aars_pkg::NUM_CH_LIMIT) &&
			mask_q[s_axis_tuser];
	assign in_val     = $signed({1'b0, s_axis_tdata[11:0], 4'b0000}) - aars_pkg::AXIS_LIMIT;

	// Configuration port, always ready.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign trk_clear = cfg_write && (cfg_index == aars_pkg::CFG_AUTORANGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
			auto_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				aars_pkg::CFG_CHANNEL_MASK: mask_q <= cfg_data[aars_pkg::NUM_CHANNELS-1:0];
				aars_pkg::CFG_AUTORANGE:    auto_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Extreme store.
	aars_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (trk_clear),
		.update  (trk_update),
		.idx     (ch_q[aars_pkg::CH_IDX_W-1:0]),
		.value   (val_q),
		.new_min (new_min),
		.new_max (new_max)
	);

	assign span_full   = new_max - new_min;
	assign offset_full = val_q - new_min;

	// Shared divider.
	assign div_req.start  = div_start;
	assign div_req.offset = offset_q;
	assign div_req.span   = range_q;

	aars_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign scaled   = $signed({1'b0, div_rsp.quotient}) - aars_pkg::AXIS_LIMIT;
	assign out_free = !out_valid_q || m_axis_tready;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aars_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			aars_pkg::ST_IDLE: begin
				if (in_accept && ch_enabled) begin
					state_d = auto_q ? aars_pkg::ST_TRACK : aars_pkg::ST_DONE;
				end
			end
			aars_pkg::ST_TRACK: state_d = aars_pkg::ST_CHECK;
			aars_pkg::ST_CHECK: begin
				state_d = (range_q > aars_pkg::SPAN_W'(1)) ? aars_pkg::ST_DIV : aars_pkg::ST_DONE;
			end
			aars_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = aars_pkg::ST_SCALE;
				end
			end
			aars_pkg::ST_SCALE: state_d = aars_pkg::ST_DONE;
			aars_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = aars_pkg::ST_IDLE;
				end
			end
			default: state_d = aars_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready   = 1'b0;
		trk_update = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			aars_pkg::ST_IDLE:  in_ready = 1'b1;
			aars_pkg::ST_TRACK: trk_update = 1'b1;
			aars_pkg::ST_CHECK: div_start = range_q > aars_pkg::SPAN_W'(1);
			default: ;
		endcase
	end

	assign s_axis_tready = in_ready;

	// Datapath registers; the unscaled value stands as result unless the
	// divider replaces it.
	always_ff @(posedge clk) begin
		case (state_q)
			aars_pkg::ST_IDLE: begin
				if (in_accept) begin
					ch_q  <= s_axis_tuser;
					val_q <= in_val;
					res_q <= in_val[aars_pkg::AXIS_W-1:0];
				end
			end
			aars_pkg::ST_TRACK: begin
				range_q  <= span_full[aars_pkg::SPAN_W-1:0];
				offset_q <= offset_full[aars_pkg::SPAN_W-1:0];
			end
			aars_pkg::ST_SCALE: begin
				if (scaled > aars_pkg::AXIS_LIMIT) begin
					res_q <= aars_pkg::AXIS_MAX;
				end else if (scaled < -aars_pkg::AXIS_LIMIT) begin
					res_q <= aars_pkg::AXIS_MIN;
				end else begin
					res_q <= scaled[aars_pkg::AXIS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == aars_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aars_pkg::ST_DONE && out_free) begin
			out_data_q <= res_q;
			out_ch_q   <= ch_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ch_q;

`ifndef SYNTH
	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == aars_pkg::ST_DIV)
		else $error("divider done outside of the divide state");

	// The offset never exceeds the span, so the quotient fits the axis span.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aars_pkg::ST_CHECK |-> offset_q <= range_q)
		else $error("offset beyond span at divider start");

	// A new output request comes only from the completion state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == aars_pkg::ST_DONE)
		else $error("output request raised outside of completion");
`endif

endmodule

`default_nettype wire

// File: dv/analog_axis_autorange_scaler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Analog axis autorange scaler testbench
// A directed table of samples and register writes is run first, followed by
// random phases under changing channel masks and autorange settings. Both
// stream sides idle at random. Every m_axis request is checked field by field
// against a table value or an in-bench scaler model tracking channel extremes.
// ----------------------------------------------------------------------------
module analog_axis_autorange_scaler_unit_tb;

	localparam int RAW_TOP      = 4095;
	localparam int FULL_SPAN    = 65535;
	localparam int AXIS_CLIP    = 32767;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASE_ITEMS  = 150;
	localparam int TAIL_CYCLES  = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [aars_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd9;
	localparam logic [aars_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST  = 4'd15;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_VALUE, EXP_NONE} row_exp_t;

	// One directed step: a sample (sel = channel, arg = raw) or a register
	// write (sel = index, arg = data).
	typedef struct packed {
		row_kind_t                      kind;
		logic [aars_pkg::CFG_IDX_W-1:0] sel;
		logic [aars_pkg::SAMPLE_W-1:0]  arg;
		row_exp_t                       ek;
		logic [aars_pkg::AXIS_W-1:0]    ev;
	} stim_row_t;

	typedef struct packed {
		logic [aars_pkg::CH_W-1:0]   chan;
		logic [aars_pkg::AXIS_W-1:0] value;
	} axis_res_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [15:0]                     s_axis_tdata = '0;
	logic [2:0]                      s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [15:0]                     m_axis_tdata;
	logic [2:0]                      m_axis_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [aars_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [aars_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Scaler model state.
	logic [7:0]                        mask_r;
	logic                              ar_on;
	logic signed [aars_pkg::VAL_W-1:0] lo_seen [aars_pkg::NUM_CHANNELS];
	logic signed [aars_pkg::VAL_W-1:0] hi_seen [aars_pkg::NUM_CHANNELS];

	axis_res_t pending_q [$];
	int        fails = 0;
	int        quiet_left = 0;

	stim_row_t dir_rows [25] = '{
		'{ROW_SAMPLE, 4'd0, 12'd0,     EXP_VALUE, 16'h8001},
		'{ROW_SAMPLE, 4'd7, 12'd4095,  EXP_VALUE, 16'h7FF1},
		'{ROW_SAMPLE, 4'd5, 12'hAAA,   EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 4'd2, 12'h555,   EXP_MODEL, 16'h0000},
		'{ROW_CFG, aars_pkg::CFG_CHANNEL_MASK, 12'h05A, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 4'd0, 12'd100,   EXP_NONE,  16'h0000},
		'{ROW_SAMPLE, 4'd1, 12'd4095,  EXP_VALUE, 16'h7FF1},
		'{ROW_CFG, CFG_IDX_SPARE, 12'h0A5, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 4'd7, 12'd7,     EXP_NONE,  16'h0000},
		'{ROW_CFG, aars_pkg::CFG_CHANNEL_MASK, 12'h0FF, EXP_NONE, 16'h0000},
		'{ROW_CFG, aars_pkg::CFG_AUTORANGE, 12'h001, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 4'd3, 12'd2048,  EXP_VALUE, 16'h0001},
		'{ROW_SAMPLE, 4'd3, 12'd2048,  EXP_VALUE, 16'h0001},
		'{ROW_SAMPLE, 4'd3, 12'd0,     EXP_VALUE, 16'h8001},
		'{ROW_SAMPLE, 4'd3, 12'd4095,  EXP_VALUE, 16'h7FFF},
		'{ROW_SAMPLE, 4'd3, 12'd1000,  EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 4'd4, 12'd4095,  EXP_VALUE, 16'h7FF1},
		'{ROW_SAMPLE, 4'd4, 12'd4094,  EXP_VALUE, 16'h8001},
		'{ROW_SAMPLE, 4'd4, 12'd4095,  EXP_VALUE, 16'h7FFF},
		'{ROW_CFG, aars_pkg::CFG_AUTORANGE, 12'h0FE, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 4'd3, 12'd4095,  EXP_VALUE, 16'h7FF1},
		'{ROW_CFG, aars_pkg::CFG_AUTORANGE, 12'h003, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 4'd3, 12'd0,     EXP_VALUE, 16'h8001},
		'{ROW_SAMPLE, 4'd3, 12'd2,     EXP_VALUE, 16'h7FFF},
		'{ROW_CFG, CFG_IDX_LAST, 12'h000, EXP_NONE, 16'h0000}
	};

	analog_axis_autorange_scaler_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Forget the tracked extremes of every channel.
	function automatic void clear_extremes();
		for (int c = 0; c < aars_pkg::NUM_CHANNELS; c++) begin
			lo_seen[c] = aars_pkg::TRACK_MIN_RESET;
			hi_seen[c] = aars_pkg::TRACK_MAX_RESET;
		end
	endfunction

	// Register write as the block applies it; unknown indexes are ignored.
	function automatic void apply_cfg(input logic [aars_pkg::CFG_IDX_W-1:0] idx,
			input logic [aars_pkg::CFG_DATA_W-1:0] dat);
		if (idx == aars_pkg::CFG_CHANNEL_MASK) begin
			mask_r = dat;
		end else if (idx == aars_pkg::CFG_AUTORANGE) begin
			clear_extremes();
			ar_on = dat[0];
		end
	endfunction

	// Centered axis value of one sample, with tracking and rescaling when
	// autoranging. Returns 0 when the channel gives no result.
	function automatic logic scale_sample(input logic [aars_pkg::CH_W-1:0] ch,
			input logic [aars_pkg::SAMPLE_W-1:0] raw,
			output logic [aars_pkg::AXIS_W-1:0] axis);
		int     v;
		int     span;
		longint q;
		axis = '0;
		if (int'(ch) >= aars_pkg::NUM_CHANNELS || !mask_r[ch])
			return 1'b0;
		v = int'(raw) * 16 - AXIS_CLIP;
		if (ar_on) begin
			if (v > int'(hi_seen[ch]))
				hi_seen[ch] = v[aars_pkg::VAL_W-1:0];
			if (v < int'(lo_seen[ch]))
				lo_seen[ch] = v[aars_pkg::VAL_W-1:0];
			span = int'(hi_seen[ch]) - int'(lo_seen[ch]);
			// A spread of 0 or 1 leaves the unscaled value.
			if (span > 1) begin
				q = longint'(v - int'(lo_seen[ch])) * FULL_SPAN / span - AXIS_CLIP;
				if (q > AXIS_CLIP)
					q = AXIS_CLIP;
				if (q < -AXIS_CLIP)
					q = -AXIS_CLIP;
				v = int'(q);
			end
		end
		axis = v[aars_pkg::AXIS_W-1:0];
		return 1'b1;
	endfunction

	// Sender gap: mostly none or short, a few long, with gap-free stretches.
	function automatic int pick_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			quiet_left = $urandom_range(20, 80);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// Offer one sample and, once taken, record what it should produce.
	task automatic offer_sample(input logic [aars_pkg::CH_W-1:0] ch,
			input logic [aars_pkg::SAMPLE_W-1:0] raw,
			input row_exp_t ek, input logic [aars_pkg::AXIS_W-1:0] ev);
		int                          gap;
		logic                        hit;
		logic [aars_pkg::AXIS_W-1:0] axis;
		axis_res_t                   item;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, raw};
		s_axis_tuser <= ch;
		do @(posedge clk); while (!s_axis_tready);
		hit = scale_sample(ch, raw, axis);
		item.chan = ch;
		item.value = (ek == EXP_VALUE) ? ev : axis;
		if (ek == EXP_VALUE || (ek == EXP_MODEL && hit))
			pending_q.insert(pending_q.size(), item);
	endtask

	// One register write; valid stays up so writes can follow back to back.
	task automatic write_reg(input logic [aars_pkg::CFG_IDX_W-1:0] idx,
			input logic [aars_pkg::CFG_DATA_W-1:0] dat);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= dat;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, dat);
	endtask

	// Drain all expected results, then let a masked sample still in flight end.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Result side: check each accepted request and pick the next ready.
	initial begin
		axis_res_t want;
		int        stall_left;
		int        calm_left;
		int        seen;
		int        next_hold;
		stall_left = 0;
		calm_left = 0;
		seen = 0;
		next_hold = 150;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				seen++;
				if (pending_q.size() == 0) begin
					$error("unexpected result: out_channel %0d axis_value %0d",
						m_axis_tuser, $signed(m_axis_tdata));
					fails++;
				end else begin
					want = pending_q.pop_front();
					if (m_axis_tuser !== want.chan) begin
						$error("out_channel: expected %0d, actual %0d", want.chan, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata !== want.value) begin
						$error("axis_value: expected %0d, actual %0d",
							$signed(want.value), $signed(m_axis_tdata));
						fails++;
					end
				end
			end
			// Long hold-off so the output register fills and the input stalls.
			if (seen >= next_hold) begin
				next_hold += 800;
				stall_left = HOLD_CYCLES;
				calm_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				m_axis_tready <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0: calm_left = $urandom_range(20, 100);
					1: stall_left = $urandom_range(15, 60);
					2, 3, 4, 5, 6: stall_left = $urandom_range(1, 3);
					default: ;
				endcase
				m_axis_tready <= (stall_left == 0);
			end
		end
	end

	// Reset, directed table, random phases, end of run.
	initial begin
		int                            sent;
		int                            used;
		int                            tried;
		int                            cap;
		int                            center [aars_pkg::NUM_CHANNELS];
		int                            r;
		logic [aars_pkg::CH_W-1:0]     ch;
		logic [aars_pkg::SAMPLE_W-1:0] raw;
		logic [7:0]                    mask_pick;
		mask_r = 8'hFF;
		ar_on = 1'b0;
		clear_extremes();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[i].sel, dir_rows[i].arg[aars_pkg::CFG_DATA_W-1:0]);
			end else begin
				offer_sample(dir_rows[i].sel[aars_pkg::CH_W-1:0], dir_rows[i].arg,
					dir_rows[i].ek, dir_rows[i].ev);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 5))
				0: mask_pick = 8'hFF;
				1: mask_pick = 8'h00;
				2: mask_pick = 8'h01 << $urandom_range(0, 7);
				default: mask_pick = 8'($urandom_range(0, 255));
			endcase
			write_reg(aars_pkg::CFG_CHANNEL_MASK, mask_pick);
			if ($urandom_range(0, 9) < 7)
				write_reg(aars_pkg::CFG_AUTORANGE, {7'($urandom_range(0, 127)),
					1'($urandom_range(0, 3) != 0)});
			if ($urandom_range(0, 3) == 0)
				write_reg(4'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));
			foreach (center[c])
				center[c] = int'($urandom_range(0, RAW_TOP));
			cap = (mask_r == 8'h00) ? 40 : 250;
			used = 0;
			tried = 0;
			while (used < PHASE_ITEMS && tried < cap && sent < RANDOM_ITEMS) begin
				// Favor enabled channels so results keep coming.
				ch = 3'($urandom_range(0, 7));
				if (mask_r != 8'h00 && $urandom_range(0, 4) != 0)
					while (!mask_r[ch])
						ch = 3'($urandom_range(0, 7));
				r = $urandom_range(0, 9);
				if (r == 0) begin
					raw = '0;
				end else if (r == 1) begin
					raw = 12'(RAW_TOP);
				end else if (r < 5) begin
					// Small steps around the channel's center.
					r = center[ch] + int'($urandom_range(0, 6)) - 3;
					raw = 12'((r < 0) ? 0 : (r > RAW_TOP) ? RAW_TOP : r);
				end else begin
					raw = 12'($urandom_range(0, RAW_TOP));
				end
				offer_sample(ch, raw, EXP_MODEL, '0);
				tried++;
				sent++;
				if (mask_r[ch])
					used++;
			end
		end
		settle();

		if (fails == 0)
			$display("analog_axis_autorange_scaler_unit_tb OK");
		else
			$display("analog_axis_autorange_scaler_unit_tb NOT OK");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#15_000_000;
		$display("analog_axis_autorange_scaler_unit_tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/aars_pkg.sv
hw/rtl/aars_div.sv
hw/rtl/aars_track.sv
hw/rtl/analog_axis_autorange_scaler_unit.sv
dv/analog_axis_autorange_scaler_unit_tb.sv
